// ===== design/rotation_matrix_to_quaternion_macros.svh =====
// assertion macros for the rotation matrix to quaternion rtl
// expects clk and rst_n in the scope of the module that uses them
`ifndef ROTATION_MATRIX_TO_QUATERNION_MACROS_SVH
`define ROTATION_MATRIX_TO_QUATERNION_MACROS_SVH

// same-cycle implication, sampled on clk, off while in reset
`define RMQ_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rmq check failed");

// next-cycle implication
`define RMQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rmq check failed");

`endif

// ===== design/rmq_pkg.sv =====
// shared constants and types for the rotation matrix to quaternion block
// no dependencies
package rmq_pkg;

  localparam int FIELD_W       = 18;
  localparam int FRAC_BITS_DEF = 16;
  localparam int MAG_W         = FIELD_W + 1;  // magnitude of a pair sum
  localparam int NUM_LANES     = 3;
  localparam int NUM_IN        = 9;
  localparam int NUM_OUT       = 4;

  typedef struct packed {
    logic en;   // whole pipe advances
    logic vld;  // word entering the unit
  } pipe_ctl_t;

  typedef enum logic [1:0] {
    BEST_X = 2'd0,
    BEST_Y = 2'd1,
    BEST_Z = 2'd2,
    BEST_W = 2'd3
  } best_t;

endpackage

// ===== design/rmq_sqrt_pipe.sv =====
// pipelined integer square root, one result bit per stage, with a sideband
// depends on rmq_pkg
module rmq_sqrt_pipe import rmq_pkg::*; #(
  parameter int RW  = 17,
  parameter int SBW = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  pipe_ctl_t       ctl_i,
  input  logic [2*RW-1:0] rad_i,
  input  logic [SBW-1:0]  side_i,
  output logic            vld_o,
  output logic [RW-1:0]   root_o,
  output logic [SBW-1:0]  side_o
);

  localparam int NP   = 2 * RW;
  localparam int REMW = RW + 1;

  logic [NP-1:0]   rad_r  [RW];
  logic [REMW-1:0] rem_r  [RW];
  logic [RW-1:0]   root_r [RW];
  logic [SBW-1:0]  side_r [RW];
  logic            vld_r  [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stg
    logic [NP-1:0]   rad_in;
    logic [REMW-1:0] rem_in;
    logic [RW-1:0]   root_in;
    logic [SBW-1:0]  side_in;
    logic            vld_in;
    logic [REMW+1:0] cur;
    logic [REMW+1:0] trial;
    logic [REMW+1:0] diff;
    logic            fit;

    if (k == 0) begin : g_first
      assign rad_in  = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign side_in = side_i;
      assign vld_in  = ctl_i.vld;
    end else begin : g_next
      assign rad_in  = rad_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign side_in = side_r[k-1];
      assign vld_in  = vld_r[k-1];
    end

    // bring down the next two radicand bits and try 4*root+1
    always_comb begin
      cur   = {rem_in, rad_in[NP-1 -: 2]};
      trial = (REMW+2)'({root_in, 2'b01});
      diff  = cur - trial;
      fit   = (cur >= trial);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (ctl_i.en) begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (ctl_i.en) begin
        rad_r[k]  <= rad_in << 2;
        rem_r[k]  <= fit ? diff[REMW-1:0] : cur[REMW-1:0];
        root_r[k] <= {root_in[RW-2:0], fit};
        side_r[k] <= side_in;
      end
    end
  end

  assign vld_o  = vld_r[RW-1];
  assign root_o = root_r[RW-1];
  assign side_o = side_r[RW-1];

endmodule

// ===== design/rmq_div_pipe.sv =====
// three-lane pipelined restoring divider: round(mag * 2^F / (4*root)),
// clipped to 2^(FIELD_W-1); one quotient bit per stage; depends on rmq_pkg
module rmq_div_pipe import rmq_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int RW        = 17,
  parameter int SBW       = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  pipe_ctl_t          ctl_i,
  input  logic [MAG_W-1:0]   mag_i [NUM_LANES],
  input  logic [RW-1:0]      root_i,
  input  logic [SBW-1:0]     side_i,
  output logic               vld_o,
  output logic [FIELD_W-1:0] mag_o [NUM_LANES],
  output logic [SBW-1:0]     side_o
);

  localparam int NUMW = MAG_W + FRAC_BITS + 1;
  localparam int DENW = RW + 2;
  localparam int CW   = ((NUMW > DENW + FIELD_W) ? NUMW : DENW + FIELD_W) + 1;
  localparam int STG  = FIELD_W + 1;
  localparam logic [FIELD_W-1:0] HALF = FIELD_W'(1) << (FIELD_W - 1);

  logic [CW-1:0]      rem_r  [STG][NUM_LANES];
  logic [FIELD_W-1:0] q_r    [STG][NUM_LANES];
  logic               ovf_r  [STG][NUM_LANES];
  logic [DENW-1:0]    den_r  [STG];
  logic [SBW-1:0]     side_r [STG];
  logic               vld_r  [STG];

  for (genvar k = 0; k < STG; k++) begin : g_stg
    logic [DENW-1:0] den_in;
    logic [SBW-1:0]  side_in;
    logic            vld_in;

    if (k == 0) begin : g_den_first
      assign den_in  = {root_i, 2'b00};
      assign side_in = side_i;
      assign vld_in  = ctl_i.vld;
    end else begin : g_den_next
      assign den_in  = den_r[k-1];
      assign side_in = side_r[k-1];
      assign vld_in  = vld_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (ctl_i.en) begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (ctl_i.en) begin
        den_r[k]  <= den_in;
        side_r[k] <= side_in;
      end
    end

    for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
      logic [CW-1:0]      rem_nxt;
      logic [FIELD_W-1:0] q_nxt;
      logic               ovf_nxt;

      if (k == 0) begin : g_first
        // numerator with half the divisor added for round-half-up
        always_comb begin
          rem_nxt = CW'({mag_i[l], {FRAC_BITS{1'b0}}}) + CW'({root_i, 1'b0});
          ovf_nxt = (rem_nxt >= (CW'(den_in) << FIELD_W));
          q_nxt   = '0;
        end
      end else begin : g_next
        logic [CW-1:0] sub;
        always_comb begin
          sub     = CW'(den_in) << (FIELD_W - k);
          ovf_nxt = ovf_r[k-1][l];
          if (rem_r[k-1][l] >= sub) begin
            rem_nxt = rem_r[k-1][l] - sub;
            q_nxt   = {q_r[k-1][l][FIELD_W-2:0], 1'b1};
          end else begin
            rem_nxt = rem_r[k-1][l];
            q_nxt   = {q_r[k-1][l][FIELD_W-2:0], 1'b0};
          end
        end
      end

      always_ff @(posedge clk) begin
        if (ctl_i.en) begin
          rem_r[k][l] <= rem_nxt;
          q_r[k][l]   <= q_nxt;
          ovf_r[k][l] <= ovf_nxt;
        end
      end
    end
  end

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_out
    assign mag_o[l] = (ovf_r[STG-1][l] || (q_r[STG-1][l] > HALF)) ? HALF : q_r[STG-1][l];
  end

  assign vld_o  = vld_r[STG-1];
  assign side_o = side_r[STG-1];

endmodule

// ===== design/rotation_matrix_to_quaternion.sv =====
// Rotation matrix to quaternion converter, top level.
// Depends on rmq_pkg, rmq_sqrt_pipe, rmq_div_pipe and the assertion macros.
//
// Input stream: one 3x3 rotation matrix per word, nine signed fixed-point
// entries with FRAC_BITS fraction bits. Output stream: one quaternion per
// word (x, y, z, w, same format, saturated) and an ok flag on out_tuser.
// The largest of the four diagonal combinations picks the component taken
// by square root; the other three come from off-diagonal pairs divided by
// four times it. When that combination is not positive, ok is low and
// all four components are zero.
// The combinations are formed in stage a and selected in stage b; the
// square root pipe then yields one root bit per stage (RW = 17 at
// FRAC_BITS = 16), the divider pipe does an overflow check and then one
// quotient bit per stage, and the output register comes last.
// It takes one word per cycle unless stalled. The whole pipe advances
// whenever the output register is empty or being taken, so a stalled
// receiver freezes every stage in place and in_tready drops; nothing is
// lost or repeated. Reset clears all valid bits, leaving the pipe ready.
module rotation_matrix_to_quaternion import rmq_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // m00, m01, m02, m10, m11, m12, m20, m21, m22, then 6 zero bits
  input  logic [167:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // quat_x, quat_y, quat_z, quat_w
  output logic [71:0]  out_tdata,
  // ok
  output logic [0:0]   out_tuser
);

  `include "rotation_matrix_to_quaternion_macros.svh"

  localparam int EW   = ((FRAC_BITS + 2 > 20) ? FRAC_BITS + 2 : 20) + 1;
  localparam int NW   = EW - 1 + FRAC_BITS - 2;
  localparam int RW   = (NW + 1) / 2;
  localparam int NP   = 2 * RW;
  localparam int CMPW = (RW > FIELD_W) ? RW : FIELD_W;
  localparam int SB1W = NUM_LANES + NUM_LANES * MAG_W + 3;
  localparam int SB2W = RW + NUM_LANES + 3;
  localparam logic [FIELD_W-1:0] QMAX = FIELD_W'((1 << (FIELD_W - 1)) - 1);
  localparam logic [FIELD_W-1:0] HALF = FIELD_W'(1) << (FIELD_W - 1);
  localparam logic signed [EW-1:0] ONE = EW'(1) << FRAC_BITS;

  logic pipe_en;
  assign pipe_en  = !out_tvalid || out_tready;
  assign in_tready = pipe_en;

  // stage a: combinations, pair sums and pair differences
  logic signed [FIELD_W-1:0] m [NUM_IN];
  logic signed [EW-1:0]      e_nxt [4];
  logic signed [EW-1:0]      e_r   [4];
  logic signed [MAG_W-1:0]   p01_r, p20_r, p12_r, d12_r, d20_r, d01_r;
  logic                      a_vld_r;

  for (genvar i = 0; i < NUM_IN; i++) begin : g_unpack
    assign m[i] = signed'(in_tdata[i*FIELD_W +: FIELD_W]);
  end

  always_comb begin
    e_nxt[0] = EW'(m[0]) - EW'(m[4]) - EW'(m[8]) + ONE;
    e_nxt[1] = -EW'(m[0]) + EW'(m[4]) - EW'(m[8]) + ONE;
    e_nxt[2] = -EW'(m[0]) - EW'(m[4]) + EW'(m[8]) + ONE;
    e_nxt[3] = EW'(m[0]) + EW'(m[4]) + EW'(m[8]) + ONE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (pipe_en) begin
      a_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      e_r   <= e_nxt;
      p01_r <= MAG_W'(m[1]) + MAG_W'(m[3]);
      p20_r <= MAG_W'(m[6]) + MAG_W'(m[2]);
      p12_r <= MAG_W'(m[5]) + MAG_W'(m[7]);
      d12_r <= MAG_W'(m[5]) - MAG_W'(m[7]);
      d20_r <= MAG_W'(m[6]) - MAG_W'(m[2]);
      d01_r <= MAG_W'(m[1]) - MAG_W'(m[3]);
    end
  end

  // stage b: pick the largest combination, lowest index on a tie
  best_t                   best;
  logic signed [EW-1:0]    e_best;
  logic                    ok_b;
  logic signed [MAG_W-1:0] lane_s [NUM_LANES];
  logic [MAG_W-1:0]        lane_mag [NUM_LANES];
  logic [NUM_LANES-1:0]    lane_neg;
  logic [NP-1:0]           rad_nxt;
  logic [NP-1:0]           rad_r;
  logic [SB1W-1:0]         sb1_r;
  logic                    b_vld_r;

  always_comb begin
    best   = BEST_X;
    e_best = e_r[0];
    if (e_r[1] > e_best) begin
      best   = BEST_Y;
      e_best = e_r[1];
    end
    if (e_r[2] > e_best) begin
      best   = BEST_Z;
      e_best = e_r[2];
    end
    if (e_r[3] > e_best) begin
      best   = BEST_W;
      e_best = e_r[3];
    end
    ok_b    = (e_best > 0);
    rad_nxt = ok_b ? (NP'(e_best[EW-2:0]) << (FRAC_BITS - 2)) : '0;
    case (best)
      BEST_X: begin
        lane_s[0] = p01_r; lane_s[1] = p20_r; lane_s[2] = d12_r;
      end
      BEST_Y: begin
        lane_s[0] = p01_r; lane_s[1] = p12_r; lane_s[2] = d20_r;
      end
      BEST_Z: begin
        lane_s[0] = p20_r; lane_s[1] = p12_r; lane_s[2] = d01_r;
      end
      default: begin
        lane_s[0] = d12_r; lane_s[1] = d20_r; lane_s[2] = d01_r;
      end
    endcase
    for (int l = 0; l < NUM_LANES; l++) begin
      lane_neg[l] = lane_s[l][MAG_W-1];
      lane_mag[l] = lane_neg[l] ? MAG_W'(-lane_s[l]) : MAG_W'(lane_s[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (pipe_en) begin
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      rad_r <= rad_nxt;
      sb1_r <= {lane_neg, lane_mag[2], lane_mag[1], lane_mag[0], best, ok_b};
    end
  end

  // square root of the chosen combination
  pipe_ctl_t        sq_ctl;
  logic             sq_vld;
  logic [RW-1:0]    sq_root;
  logic [SB1W-1:0]  sq_side;

  assign sq_ctl = '{en: pipe_en, vld: b_vld_r};

  rmq_sqrt_pipe #(
    .RW  (RW),
    .SBW (SB1W)
  ) u_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl_i  (sq_ctl),
    .rad_i  (rad_r),
    .side_i (sb1_r),
    .vld_o  (sq_vld),
    .root_o (sq_root),
    .side_o (sq_side)
  );

  // divide the three selected pair sums or differences by four times the root
  pipe_ctl_t          dv_ctl;
  logic [MAG_W-1:0]   dv_mag [NUM_LANES];
  logic [SB2W-1:0]    dv_side_in;
  logic               dv_vld;
  logic [FIELD_W-1:0] dv_mag_o [NUM_LANES];
  logic [SB2W-1:0]    dv_side;

  assign dv_ctl     = '{en: pipe_en, vld: sq_vld};
  assign dv_mag[0]  = sq_side[3 +: MAG_W];
  assign dv_mag[1]  = sq_side[3 + MAG_W +: MAG_W];
  assign dv_mag[2]  = sq_side[3 + 2*MAG_W +: MAG_W];
  assign dv_side_in = {sq_root, sq_side[SB1W-1 -: NUM_LANES], sq_side[2:0]};

  rmq_div_pipe #(
    .FRAC_BITS (FRAC_BITS),
    .RW        (RW),
    .SBW       (SB2W)
  ) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl_i  (dv_ctl),
    .mag_i  (dv_mag),
    .root_i (sq_root),
    .side_i (dv_side_in),
    .vld_o  (dv_vld),
    .mag_o  (dv_mag_o),
    .side_o (dv_side)
  );

  // output stage: signs, saturation, placement
  logic [RW-1:0]             fin_root;
  logic [NUM_LANES-1:0]      fin_neg;
  best_t                     fin_best;
  logic                      fin_ok;
  logic [CMPW-1:0]           root_ext;
  logic [FIELD_W-1:0]        chosen;
  logic [FIELD_W-1:0]        lane_q [NUM_LANES];
  logic [FIELD_W-1:0]        comp [NUM_OUT];
  logic [NUM_OUT*FIELD_W-1:0] tdata_nxt;
  logic [NUM_OUT*FIELD_W-1:0] out_tdata_r;
  logic                      ok_r;
  best_t                     best_r;
  logic                      out_tvalid_r;

  assign fin_root = dv_side[SB2W-1 -: RW];
  assign fin_neg  = dv_side[3 +: NUM_LANES];
  assign fin_best = best_t'(dv_side[2:1]);
  assign fin_ok   = dv_side[0];

  always_comb begin
    root_ext = CMPW'(fin_root);
    chosen   = (root_ext > CMPW'(QMAX)) ? QMAX : root_ext[FIELD_W-1:0];
    for (int l = 0; l < NUM_LANES; l++) begin
      if (fin_neg[l]) begin
        lane_q[l] = -dv_mag_o[l];
      end else begin
        lane_q[l] = (dv_mag_o[l] == HALF) ? QMAX : dv_mag_o[l];
      end
    end
    case (fin_best)
      BEST_X: begin
        comp[0] = chosen; comp[1] = lane_q[0]; comp[2] = lane_q[1]; comp[3] = lane_q[2];
      end
      BEST_Y: begin
        comp[0] = lane_q[0]; comp[1] = chosen; comp[2] = lane_q[1]; comp[3] = lane_q[2];
      end
      BEST_Z: begin
        comp[0] = lane_q[0]; comp[1] = lane_q[1]; comp[2] = chosen; comp[3] = lane_q[2];
      end
      default: begin
        comp[0] = lane_q[0]; comp[1] = lane_q[1]; comp[2] = lane_q[2]; comp[3] = chosen;
      end
    endcase
    tdata_nxt = fin_ok ? {comp[3], comp[2], comp[1], comp[0]} : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (pipe_en) begin
      out_tvalid_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      out_tdata_r <= tdata_nxt;
      ok_r        <= fin_ok;
      best_r      <= fin_best;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = ok_r;

  `RMQ_ASSERT_IMPL(a_fail_zero, out_tvalid_r && !ok_r, out_tdata_r == '0)
  `RMQ_ASSERT_IMPL(a_chosen_pos, out_tvalid_r && ok_r,
                   !out_tdata_r[FIELD_W*int'(best_r) + FIELD_W - 1])
  `RMQ_ASSERT_NEXT(a_accept_enters, in_tvalid && in_tready, a_vld_r)
  `RMQ_ASSERT_NEXT(a_stall_freeze, !pipe_en, $stable(a_vld_r) && $stable(b_vld_r))

endmodule
